// ===== hw/rtl/ast_pkg.sv =====
`default_nettype none

package ast_pkg;

  localparam int unsigned KindW  = 5;
  localparam int unsigned ValueW = 16;
  localparam int unsigned LenW   = 11;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ErrW   = 3;

  // Packed word width on the result side: fields padded to whole bytes
  localparam int unsigned FieldsW = ValueW + LenW + PosW + PosW + ErrW;
  localparam int unsigned OutDataW = ((FieldsW + 7) / 8) * 8;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
    logic [PosW-1:0]   line;
    logic [PosW-1:0]   column;
    logic [ErrW-1:0]   err;
  } res_t;

  // Up to two results leave the scanner for one byte
  typedef struct packed {
    logic [1:0] vld;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/assembly_source_tokenizer.sv =====
// Channel  Direction  Handshake                       Payload
// s_axis   in         s_axis_tvalid / s_axis_tready   tdata: source byte; tlast: end of input
// m_axis   out        m_axis_tvalid / m_axis_tready   tdata: token fields; tuser: token kind
//
// One source byte is taken per cycle while the queue has room. Each byte is scanned
// in the cycle it is accepted and yields zero, one or two results, which are written
// into a four-entry result queue; the queue head drives the output channel directly.
// A byte is taken while the queue has room for two results, so with one result
// per byte the sustained rate is one byte per cycle; a byte that ends a token
// and opens the next adds one result, which the output drains at one per cycle.
// Reset (rst_ni low) empties the queue and returns the scanner to idle at line 1,
// column 1. A stall on m_axis fills the queue and then holds s_axis_tready low.
`default_nettype none

module assembly_source_tokenizer #(
  parameter int unsigned MAX_TEXT_LEN = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  input  wire logic                          s_axis_tlast,  // at_end
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] token_value, [26:16] text_length, [42:27] start_line,
  // [58:43] start_column, [61:59] error_code, [63:62] zero
  output logic [ast_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [ast_pkg::KindW-1:0]          m_axis_tuser   // [4:0] token_kind
);

  logic               step;
  logic               room2;
  ast_pkg::res_pair_t res_pair;
  ast_pkg::res_t      head;

  // Take a byte only when both results it may raise fit in the queue
  assign s_axis_tready = room2;
  assign step          = s_axis_tvalid && room2;

  ast_scanner #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s_axis_tdata),
    .at_end_i (s_axis_tlast),
    .res_o    (res_pair)
  );

  ast_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_pair),
    .room2_o (room2),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  // Pack the word, first field in the lowest bits, zero pad to whole bytes
  assign m_axis_tdata = ast_pkg::OutDataW'({head.err, head.column, head.line,
                                            head.length, head.value});
  assign m_axis_tuser = head.kind;

endmodule

`default_nettype wire

// ===== hw/rtl/ast_scanner.sv =====
`default_nettype none

module ast_scanner #(
  parameter int unsigned MAX_TEXT_LEN = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              at_end_i,
  output ast_pkg::res_pair_t     res_o
);

  localparam int unsigned CntW = $clog2(MAX_TEXT_LEN + 1);

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_COMMENT    = 4'd1;
  localparam logic [3:0] M_STRING     = 4'd2;
  localparam logic [3:0] M_STRING_ESC = 4'd3;
  localparam logic [3:0] M_CHAR_OPEN  = 4'd4;
  localparam logic [3:0] M_CHAR_ESC   = 4'd5;
  localparam logic [3:0] M_CHAR_CLOSE = 4'd6;
  localparam logic [3:0] M_INT_ZERO   = 4'd7;
  localparam logic [3:0] M_INT_DIGITS = 4'd8;
  localparam logic [3:0] M_IDENT      = 4'd9;

  localparam logic [1:0] B_DEC = 2'd0;
  localparam logic [1:0] B_HEX = 2'd1;
  localparam logic [1:0] B_BIN = 2'd2;

  localparam logic [4:0] K_NEWLINE = 5'd8;
  localparam logic [4:0] K_INT     = 5'd9;
  localparam logic [4:0] K_CHAR    = 5'd10;
  localparam logic [4:0] K_STR     = 5'd11;
  localparam logic [4:0] K_IDENT   = 5'd12;
  localparam logic [4:0] K_MACRO   = 5'd13;
  localparam logic [4:0] K_EOF     = 5'd14;
  localparam logic [4:0] K_TEXT    = 5'd15;
  localparam logic [4:0] K_ERR     = 5'd16;

  localparam logic [2:0] E_NONE        = 3'd0;
  localparam logic [2:0] E_BAD_CHAR    = 3'd1;
  localparam logic [2:0] E_OPEN_STR    = 3'd2;
  localparam logic [2:0] E_OPEN_CHAR   = 3'd3;
  localparam logic [2:0] E_BAD_ESC     = 3'd4;
  localparam logic [2:0] E_STR_LONG    = 3'd5;
  localparam logic [2:0] E_INT_LARGE   = 3'd6;
  localparam logic [2:0] E_IDENT_LONG  = 3'd7;

  localparam logic [2:0]  KwFail = 3'd6;
  localparam logic [2:0]  KwLen  = 3'd5;
  localparam logic [15:0] VMax   = 16'hFFFF;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TEXT_LEN);

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "m";
      3'd1:    c = "a";
      3'd2:    c = "c";
      3'd3:    c = "r";
      3'd4:    c = "o";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // {hit, escaped byte}
  function automatic logic [8:0] escape_of(input logic [7:0] b, input logic [7:0] quote);
    logic [8:0] r;
    if (b == "n") begin
      r = {1'b1, 8'h0A};
    end else if (b == "t") begin
      r = {1'b1, 8'h09};
    end else if (b == "r") begin
      r = {1'b1, 8'h0D};
    end else if (b == "\\" || b == quote) begin
      r = {1'b1, b};
    end else begin
      r = 9'd0;
    end
    return r;
  endfunction

  // {hit, punctuation kind}
  function automatic logic [5:0] punct_of(input logic [7:0] b);
    logic [5:0] r;
    unique case (b)
      ",":     r = {1'b1, 5'd0};
      ":":     r = {1'b1, 5'd1};
      "%":     r = {1'b1, 5'd2};
      "$":     r = {1'b1, 5'd3};
      ".":     r = {1'b1, 5'd4};
      "!":     r = {1'b1, 5'd5};
      "-":     r = {1'b1, 5'd6};
      ";":     r = {1'b1, 5'd7};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  logic [3:0]      mode_q, mode_d;
  logic [15:0]     acc_q, acc_d;
  logic [1:0]      base_q, base_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      kwp_q, kwp_d;
  logic [7:0]      chr_q, chr_d;
  logic [15:0]     line_q, line_d;
  logic [15:0]     col_q, col_d;
  logic [15:0]     sline_q, sline_d;
  logic [15:0]     scol_q, scol_d;

  logic        eof;
  logic        again;
  logic [4:0]  digit;
  logic        digit_ok;
  logic [20:0] scaled;
  logic [20:0] acc_sum;
  logic [8:0]  esc;
  logic [5:0]  punct;
  logic [31:0] cnt_ext;

  // mode in progress result first when it emits, idle pass or eof result after it
  logic        m_emit, i_emit;
  logic [4:0]  m_kind, i_kind;
  logic [15:0] m_val, i_val;
  logic        m_len_en;
  logic [2:0]  m_err, i_err;

  ast_pkg::res_t m_res, i_res;

  assign eof     = at_end_i || (byte_i == 8'd0);
  assign cnt_ext = 32'(cnt_q);
  assign esc     = escape_of(byte_i, (mode_q == M_CHAR_ESC) ? 8'h27 : 8'h22);
  assign punct   = punct_of(byte_i);

  always_comb begin
    digit    = 5'd0;
    digit_ok = 1'b0;
    if (is_digit(byte_i)) begin
      digit    = 5'(byte_i - "0");
      digit_ok = (base_q != B_BIN) || (byte_i <= "1");
    end else if (base_q == B_HEX && byte_i >= "a" && byte_i <= "f") begin
      digit    = 5'(byte_i - "a" + 8'd10);
      digit_ok = 1'b1;
    end else if (base_q == B_HEX && byte_i >= "A" && byte_i <= "F") begin
      digit    = 5'(byte_i - "A" + 8'd10);
      digit_ok = 1'b1;
    end
  end

  always_comb begin
    unique case (base_q)
      B_HEX:   scaled = {1'b0, acc_q, 4'd0};
      B_BIN:   scaled = {4'd0, acc_q, 1'b0};
      default: scaled = {2'd0, acc_q, 3'd0} + {4'd0, acc_q, 1'b0};
    endcase
    acc_sum = scaled + 21'(digit);
  end

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    kwp_d   = kwp_q;
    chr_d   = chr_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    again   = 1'b0;
    m_emit  = 1'b0;
    m_kind  = K_ERR;
    m_val   = 16'd0;
    m_len_en = 1'b0;
    m_err   = E_NONE;
    i_emit  = 1'b0;
    i_kind  = K_EOF;
    i_val   = 16'd0;
    i_err   = E_NONE;

    if (eof) begin
      unique case (mode_q)
        M_STRING: begin
          m_emit = 1'b1;
          m_err  = E_OPEN_STR;
        end
        M_STRING_ESC, M_CHAR_ESC: begin
          m_emit = 1'b1;
          m_err  = E_BAD_ESC;
        end
        M_CHAR_OPEN, M_CHAR_CLOSE: begin
          m_emit = 1'b1;
          m_err  = E_OPEN_CHAR;
        end
        M_INT_ZERO, M_INT_DIGITS: begin
          m_emit = 1'b1;
          m_kind = K_INT;
          m_val  = acc_q;
        end
        M_IDENT: begin
          m_emit = 1'b1;
          if (kwp_q == KwLen && cnt_ext == 32'd5) begin
            m_kind = K_MACRO;
          end else begin
            m_kind   = K_IDENT;
            m_len_en = 1'b1;
          end
        end
        default: begin
        end
      endcase
      mode_d  = M_IDLE;
      sline_d = line_q;
      scol_d  = col_q;
      i_emit  = 1'b1;
      i_kind  = K_EOF;
    end else begin
      unique case (mode_q)
        M_COMMENT: begin
          if (byte_i == 8'h0A) begin
            mode_d = M_IDLE;
            again  = 1'b1;
          end
        end
        M_STRING, M_STRING_ESC: begin
          if (mode_q == M_STRING && byte_i == 8'h22) begin
            mode_d   = M_IDLE;
            m_emit   = 1'b1;
            m_kind   = K_STR;
            m_len_en = 1'b1;
          end else if (mode_q == M_STRING && byte_i == 8'h5C) begin
            mode_d = M_STRING_ESC;
          end else if (mode_q == M_STRING_ESC && !esc[8]) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_err  = E_BAD_ESC;
          end else if (cnt_q >= CntMax) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_err  = E_STR_LONG;
          end else begin
            cnt_d  = cnt_q + 1'b1;
            mode_d = M_STRING;
            m_emit = 1'b1;
            m_kind = K_TEXT;
            m_val  = {8'd0, (mode_q == M_STRING) ? byte_i : esc[7:0]};
          end
        end
        M_CHAR_OPEN: begin
          if (byte_i == 8'h5C) begin
            mode_d = M_CHAR_ESC;
          end else begin
            chr_d  = byte_i;
            mode_d = M_CHAR_CLOSE;
          end
        end
        M_CHAR_ESC: begin
          if (!esc[8]) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_err  = E_BAD_ESC;
          end else begin
            chr_d  = esc[7:0];
            mode_d = M_CHAR_CLOSE;
          end
        end
        M_CHAR_CLOSE: begin
          mode_d = M_IDLE;
          m_emit = 1'b1;
          if (byte_i == 8'h27) begin
            m_kind = K_CHAR;
            m_val  = {8'd0, chr_q};
          end else begin
            m_err = E_OPEN_CHAR;
          end
        end
        M_INT_ZERO, M_INT_DIGITS: begin
          if (mode_q == M_INT_ZERO && (byte_i == "x" || byte_i == "b")) begin
            base_d = (byte_i == "x") ? B_HEX : B_BIN;
            acc_d  = 16'd0;
            mode_d = M_INT_DIGITS;
          end else if (!digit_ok) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_kind = K_INT;
            m_val  = acc_q;
            again  = 1'b1;
          end else if (acc_sum > 21'(VMax)) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_err  = E_INT_LARGE;
          end else begin
            mode_d = M_INT_DIGITS;
            acc_d  = acc_sum[15:0];
          end
        end
        M_IDENT: begin
          if (!(is_alpha(byte_i) || is_digit(byte_i))) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            if (kwp_q == KwLen && cnt_ext == 32'd5) begin
              m_kind = K_MACRO;
            end else begin
              m_kind   = K_IDENT;
              m_len_en = 1'b1;
            end
            again = 1'b1;
          end else if (cnt_q >= CntMax) begin
            mode_d = M_IDLE;
            m_emit = 1'b1;
            m_err  = E_IDENT_LONG;
          end else begin
            if (cnt_ext < 32'd5 && 32'(kwp_q) == cnt_ext
                && byte_i == kw_char(cnt_ext[2:0])) begin
              kwp_d = kwp_q + 3'd1;
            end else begin
              kwp_d = KwFail;
            end
            cnt_d  = cnt_q + 1'b1;
            m_emit = 1'b1;
            m_kind = K_TEXT;
            m_val  = {8'd0, byte_i};
          end
        end
        default: begin
          mode_d = M_IDLE;
          again  = 1'b1;
        end
      endcase

      // Idle pass: the byte opens a new token, or is skipped as whitespace
      if (again) begin
        sline_d = line_q;
        scol_d  = col_q;
        if (byte_i == " " || byte_i == 8'h09) begin
          // skip whitespace
        end else if (byte_i == "#") begin
          mode_d = M_COMMENT;
        end else if (byte_i == 8'h0A) begin
          i_emit = 1'b1;
          i_kind = K_NEWLINE;
        end else if (punct[5]) begin
          i_emit = 1'b1;
          i_kind = punct[4:0];
        end else if (byte_i == 8'h22) begin
          mode_d = M_STRING;
          cnt_d  = '0;
        end else if (byte_i == 8'h27) begin
          mode_d = M_CHAR_OPEN;
          chr_d  = 8'd0;
        end else if (is_digit(byte_i)) begin
          base_d = B_DEC;
          acc_d  = {12'd0, byte_i[3:0]};
          mode_d = (byte_i == "0") ? M_INT_ZERO : M_INT_DIGITS;
        end else if (is_alpha(byte_i)) begin
          mode_d = M_IDENT;
          cnt_d  = CntW'(1);
          kwp_d  = (byte_i == kw_char(3'd0)) ? 3'd1 : KwFail;
          i_emit = 1'b1;
          i_kind = K_TEXT;
          i_val  = {8'd0, byte_i};
        end else begin
          i_emit = 1'b1;
          i_kind = K_ERR;
          i_err  = E_BAD_CHAR;
        end
      end

      // Advance the position of the next byte, saturating
      if (byte_i == 8'h0A) begin
        if (line_q < VMax) begin
          line_d = line_q + 16'd1;
        end
        col_d = 16'd1;
      end else if (col_q < VMax) begin
        col_d = col_q + 16'd1;
      end
    end
  end

  always_comb begin
    m_res.kind   = m_kind;
    m_res.value  = m_val;
    m_res.length = m_len_en ? cnt_ext[10:0] : 11'd0;
    m_res.line   = sline_q;
    m_res.column = scol_q;
    m_res.err    = m_err;
    i_res.kind   = i_kind;
    i_res.value  = i_val;
    i_res.length = 11'd0;
    i_res.line   = line_q;
    i_res.column = col_q;
    i_res.err    = i_err;

    res_o.vld = 2'b00;
    res_o.r0  = m_emit ? m_res : i_res;
    res_o.r1  = i_res;
    if (step_i) begin
      res_o.vld = {m_emit && i_emit, m_emit || i_emit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= 16'd0;
      base_q  <= B_DEC;
      cnt_q   <= '0;
      kwp_q   <= 3'd0;
      chr_q   <= 8'd0;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      sline_q <= 16'd1;
      scol_q  <= 16'd1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      kwp_q   <= kwp_d;
      chr_q   <= chr_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ast_out_fifo.sv =====
`default_nettype none

module ast_out_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  ast_pkg::res_pair_t      push_i,
  output logic                    room2_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output ast_pkg::res_t           data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  ast_pkg::res_t mem_q [Depth];

  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;
  logic [PtrW:0]   n_push;

  assign pop     = valid_o && ready_i;
  assign n_push  = (PtrW+1)'(push_i.vld[0]) + (PtrW+1)'(push_i.vld[1]);
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.vld[1]) begin
      mem_q[wp_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_push[PtrW-1:0];
      if (pop) begin
        rp_q <= rp_q + PtrW'(1);
      end
      cnt_q <= cnt_q + n_push - (PtrW+1)'(pop);
    end
  end

endmodule

`default_nettype wire
